### src/lrp_pkg.sv
// Shared types and codes for the LR shift-reduce parser core.
// No dependencies; imported by lrp_ram users and the top level.
package lrp_pkg;

  localparam int unsigned StateW = 8;
  localparam int unsigned TermW  = 6;
  localparam int unsigned NtW    = 6;
  localparam int unsigned ProdW  = 8;
  localparam int unsigned RhsW   = 4;
  localparam int unsigned RedW   = 17;   // counts up to the reduction cap

  localparam int unsigned ActDepth  = 16384;
  localparam int unsigned GotoDepth = 16384;
  localparam int unsigned ProdDepth = 256;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_ACT   = 2'd1,
    KIND_GOTO  = 2'd2,
    KIND_PROD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_ERROR  = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_REDUCE = 2'd2,
    ACT_ACCEPT = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_SHIFTED   = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_SYNTAX    = 3'd2,
    ST_GOTO_MISS = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_WRITTEN   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_ACT,
    FSM_PROD,
    FSM_POP,
    FSM_GOTO
  } fsm_e;

endpackage

### src/lrp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/lr_shift_reduce_parser_core.sv
// Top level of the table-driven LR shift-reduce parser.
// Depends on lrp_pkg and lrp_ram.
//
// Channel   | Direction | Ports                                   | Handshake
// ----------+-----------+-----------------------------------------+-------------------------
// item      | in        | kind_i .. lhs_symbol_i                  | start_i && !busy_o
// result    | out       | status_o, reduce_count_o, top_state_o   | done_o, one cycle
// config    | in        | cfg_wdata_i                             | cfg_we_i
//
// A table write's result appears the cycle after acceptance.
// A token runs through ACT and, for each reduction, PROD, POP and GOTO:
// every step waits on one registered read of the action, production, stack or goto memory.
// Reset returns the stack to one entry holding state 0; table contents are
// kept undefined until written, so no clearing pass is run.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lr_shift_reduce_parser_core #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   kind_i,
  input  logic [lrp_pkg::TermW-1:0]    terminal_i,
  input  logic [lrp_pkg::StateW-1:0]   table_state_i,
  input  logic [lrp_pkg::NtW-1:0]      nonterminal_i,
  input  logic [1:0]                   action_code_i,
  input  logic [lrp_pkg::StateW-1:0]   entry_value_i,
  input  logic                         goto_valid_i,
  input  logic [lrp_pkg::ProdW-1:0]    production_number_i,
  input  logic [lrp_pkg::RhsW-1:0]     rhs_length_i,
  input  logic [lrp_pkg::NtW-1:0]      lhs_symbol_i,
  input  logic                         cfg_we_i,
  input  logic [lrp_pkg::TermW-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [7:0]                   reduce_count_o,
  output logic [lrp_pkg::StateW-1:0]   top_state_o
);
  import lrp_pkg::*;

  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW  = SPW + RhsW + 1;
  localparam int unsigned AAW = $clog2(ActDepth);
  localparam int unsigned GAW = $clog2(GotoDepth);
  localparam int unsigned PAW = $clog2(ProdDepth);

  fsm_e                state_q, state_d;
  logic [SPW-1:0]      sp_q, sp_d;
  logic [StateW-1:0]   top_q, top_d;
  logic [TermW-1:0]    col_q, col_d, col_in;
  logic [TermW-1:0]    tcount_q;
  logic [NtW-1:0]      lhs_q, lhs_d;
  logic [RedW-1:0]     red_q, red_d;
  logic                bot_q, bot_d;
  logic                done_q, done_d;
  logic [2:0]          status_q, status_d;
  logic [7:0]          rcnt_q, rcnt_d;
  logic [StateW-1:0]   otop_q, otop_d;

  logic                accept;
  logic [AAW-1:0]      act_raddr;
  logic [9:0]          act_rdata;
  logic [8:0]          goto_rdata;
  logic [9:0]          prod_rdata;
  logic [StateW-1:0]   stk_rdata;
  logic                stk_we;
  logic [StateW-1:0]   stk_wdata;
  logic [SIW-1:0]      stk_raddr;
  logic [CW-1:0]       sp_ext, plen_ext, sp_pop;
  logic                full;
  logic [7:0]          red_sat;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != FSM_IDLE);
  // Out-of-range terminals fall into the end marker column.
  assign col_in = (terminal_i >= tcount_q) ? tcount_q : terminal_i;
  assign full   = (sp_q == SPW'(STACK_DEPTH));
  assign sp_ext   = CW'(sp_q);
  assign plen_ext = CW'(prod_rdata[9:6]);
  assign sp_pop   = sp_ext - plen_ext;
  assign stk_raddr = SIW'(sp_pop - CW'(1));
  assign red_sat  = (red_q > RedW'(255)) ? 8'd255 : red_q[7:0];

  // Action lookup: top of stack on a new token, new goto target after a reduction.
  assign act_raddr = (state_q == FSM_GOTO) ? {goto_rdata[StateW-1:0], col_q}
                                           : {top_q, col_in};

  lrp_ram #(.WIDTH(10), .DEPTH(ActDepth)) u_act (
    .clk_i,
    .we_i    (accept && kind_i == KIND_ACT),
    .waddr_i ({table_state_i, terminal_i}),
    .wdata_i ({action_code_i, entry_value_i}),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  lrp_ram #(.WIDTH(9), .DEPTH(GotoDepth)) u_goto (
    .clk_i,
    .we_i    (accept && kind_i == KIND_GOTO),
    .waddr_i (GAW'({table_state_i, nonterminal_i})),
    .wdata_i ({goto_valid_i, entry_value_i}),
    .raddr_i (GAW'({(bot_q ? StateW'(0) : stk_rdata), lhs_q})),
    .rdata_o (goto_rdata)
  );

  lrp_ram #(.WIDTH(10), .DEPTH(ProdDepth)) u_prod (
    .clk_i,
    .we_i    (accept && kind_i == KIND_PROD),
    .waddr_i (PAW'(production_number_i)),
    .wdata_i ({rhs_length_i, lhs_symbol_i}),
    .raddr_i (PAW'(act_rdata[7:0])),
    .rdata_o (prod_rdata)
  );

  // Stack memory; the bottom entry is never written and reads as state 0.
  lrp_ram #(.WIDTH(StateW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i,
    .we_i    (stk_we),
    .waddr_i (sp_q[SIW-1:0]),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    state_d  = state_q;
    sp_d     = sp_q;
    top_d    = top_q;
    col_d    = col_q;
    lhs_d    = lhs_q;
    red_d    = red_q;
    bot_d    = bot_q;
    done_d   = 1'b0;
    status_d = status_q;
    rcnt_d   = rcnt_q;
    otop_d   = otop_q;
    stk_we   = 1'b0;
    stk_wdata = act_rdata[7:0];
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_TOKEN) begin
            col_d   = col_in;
            red_d   = '0;
            state_d = FSM_ACT;
          end else begin
            // Table write: report at once with the current top.
            done_d   = 1'b1;
            status_d = ST_WRITTEN;
            rcnt_d   = 8'd0;
            otop_d   = top_q;
          end
        end
      end
      FSM_ACT: begin
        case (act_e'(act_rdata[9:8]))
          ACT_SHIFT: begin
            if (full) begin
              status_d = ST_OVERFLOW;
            end else begin
              stk_we   = 1'b1;
              sp_d     = sp_q + SPW'(1);
              top_d    = act_rdata[7:0];
              status_d = ST_SHIFTED;
            end
            state_d = FSM_IDLE;
            done_d  = 1'b1;
          end
          ACT_REDUCE: begin
            if (red_q[RedW-1]) begin
              status_d = ST_SYNTAX;
              state_d  = FSM_IDLE;
              done_d   = 1'b1;
            end else begin
              state_d = FSM_PROD;
            end
          end
          ACT_ACCEPT: begin
            status_d = ST_ACCEPTED;
            state_d  = FSM_IDLE;
            done_d   = 1'b1;
          end
          default: begin
            status_d = ST_SYNTAX;
            state_d  = FSM_IDLE;
            done_d   = 1'b1;
          end
        endcase
      end
      FSM_PROD: begin
        if (plen_ext > sp_ext - CW'(1)) begin
          status_d = ST_UNDERFLOW;
          state_d  = FSM_IDLE;
          done_d   = 1'b1;
        end else begin
          sp_d    = sp_pop[SPW-1:0];
          lhs_d   = prod_rdata[NtW-1:0];
          bot_d   = (sp_pop == CW'(1));
          state_d = FSM_POP;
        end
      end
      FSM_POP: begin
        top_d   = bot_q ? '0 : stk_rdata;
        state_d = FSM_GOTO;
      end
      FSM_GOTO: begin
        if (!goto_rdata[8]) begin
          status_d = ST_GOTO_MISS;
          state_d  = FSM_IDLE;
          done_d   = 1'b1;
        end else if (full) begin
          status_d = ST_OVERFLOW;
          state_d  = FSM_IDLE;
          done_d   = 1'b1;
        end else begin
          // Push the goto target and look up the action for it.
          stk_we    = 1'b1;
          stk_wdata = goto_rdata[StateW-1:0];
          sp_d      = sp_q + SPW'(1);
          top_d     = goto_rdata[StateW-1:0];
          red_d     = red_q + RedW'(1);
          state_d   = FSM_ACT;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
    // Finish a token: drop the stack to its bottom entry unless shifted.
    if (done_d && state_q != FSM_IDLE) begin
      rcnt_d = red_sat;
      if (status_d != ST_SHIFTED) begin
        sp_d  = SPW'(1);
        top_d = '0;
      end
      otop_d = top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      sp_q     <= SPW'(1);
      top_q    <= '0;
      tcount_q <= TermW'(63);
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      top_q   <= top_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        tcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q    <= col_d;
    lhs_q    <= lhs_d;
    red_q    <= red_d;
    bot_q    <= bot_d;
    status_q <= status_d;
    rcnt_q   <= rcnt_d;
    otop_q   <= otop_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign reduce_count_o = rcnt_q;
  assign top_state_o    = otop_q;

  a_sp_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q != '0) else $error("stack pointer reached zero");
  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while still busy");
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_SHIFTED && status_o != ST_WRITTEN
      |-> top_state_o == '0 && sp_q == SPW'(1))
    else $error("stack not cleared after token outcome");

endmodule
